// ===== rtl/core/taf_pkg.sv =====
// Shared types, constants and the sine table of the triangle affine transform.
package taf_pkg;

	// Coordinate format: signed, FRAC_BITS fraction bits in a 32-bit word
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;

	// Sine table: power-of-two depth, entries in signed Q1.14
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
	localparam int TRIG_W           = 16;

	// Quarter turn in turn_angle units, gives cos from the sine table
	localparam logic [15:0] QUARTER_TURN = 16'h4000;

	// Reset vertices (a, b, c)
	localparam logic signed [COORD_W-1:0] RESET_X [3] = '{
		COORD_W'(100 << FRAC_BITS), COORD_W'(100 << FRAC_BITS), COORD_W'(150 << FRAC_BITS)
	};
	localparam logic signed [COORD_W-1:0] RESET_Y [3] = '{
		COORD_W'(100 << FRAC_BITS), COORD_W'(200 << FRAC_BITS), COORD_W'(150 << FRAC_BITS)
	};

	// Command codes
	typedef enum logic [1:0] {
		ACT_SHOW      = 2'd0,
		ACT_TRANSLATE = 2'd1,
		ACT_SCALE     = 2'd2,
		ACT_ROTATE    = 2'd3
	} action_t;

	// One transformed vertex plus its saturation flag
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      clip;
	} vertex_res_t;

	// Table build constants (evaluated at elaboration only)
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SERIES_DIV [7] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
	};

	typedef logic signed [TRIG_W-1:0] sine_tab_t [SINE_TABLE_DEPTH];

	// sin(2*pi*k/depth): quadrant reduction and Taylor series in Q30
	function automatic logic signed [TRIG_W-1:0] sine_entry(input int unsigned k);
		logic [63:0]        a;
		logic [63:0]        r;
		logic [63:0]        theta;
		logic [63:0]        mag;
		logic signed [63:0] sum;
		logic [63:0]        q14;
		logic [1:0]         quad;
		a = ((64'(k) << 32) / 64'(SINE_TABLE_DEPTH)) & 64'hFFFF_FFFF;
		quad = a[31:30];
		r = a & (Q30_ONE - 64'd1);
		if (quad[0]) begin
			r = Q30_ONE - r;
		end
		theta = (r * HALF_PI_Q30) >> 30;
		mag = theta;
		sum = $signed(theta);
		for (int n = 1; n <= 7; n++) begin
			mag = (((mag * theta) >> 30) * theta) >> 30;
			mag = mag / SERIES_DIV[n-1];
			if (n % 2 == 1) begin
				sum = sum - $signed(mag);
			end else begin
				sum = sum + $signed(mag);
			end
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		q14 = ($unsigned(sum) + 64'd32768) >> 16;
		if (q14 > 64'd16384) begin
			q14 = 64'd16384;
		end
		return quad[1] ? -$signed(TRIG_W'(q14)) : $signed(TRIG_W'(q14));
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			t[k] = sine_entry(k);
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== rtl/core/triangle_affine_transform_top.sv =====
// Top level of the triangle affine transform: input stage, vertex state, result register.
//
// Holds the three vertices of a triangle in signed Q16.16 and applies one
// command per item: show, translate, scale about the origin (Q8.8 factors
// in the low operand bits) or rotate about the origin by turn_angle.
// Command channel: cmd_valid/cmd_ready with action, x_operand, y_operand,
// turn_angle. Result channel: res_valid/res_ready with all six coordinates
// after the command and clipped, set when any coordinate saturated.
// An accepted item is held in the input register, where its sine
// and cosine are already looked up; from there it moves into the
// vertex registers, which raise res_valid.
// One item per cycle is sustained while the receiver takes every result; the limit is the
// combinational multiply, round and clamp loop through the vertex registers.
// When the receiver stalls, the result holds and one more item is taken
// into the input register; cmd_ready then drops until the result moves.
// Reset empties both stages, clears clipped and loads the vertices
// (100,100), (100,200), (150,150).
module triangle_affine_transform_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  logic [1:0]                         action,
	input  logic signed [taf_pkg::COORD_W-1:0] x_operand,
	input  logic signed [taf_pkg::COORD_W-1:0] y_operand,
	input  logic [15:0]                        turn_angle,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic signed [taf_pkg::COORD_W-1:0] vertex_a_x,
	output logic signed [taf_pkg::COORD_W-1:0] vertex_a_y,
	output logic signed [taf_pkg::COORD_W-1:0] vertex_b_x,
	output logic signed [taf_pkg::COORD_W-1:0] vertex_b_y,
	output logic signed [taf_pkg::COORD_W-1:0] vertex_c_x,
	output logic signed [taf_pkg::COORD_W-1:0] vertex_c_y,
	output logic                               clipped
);
	import taf_pkg::*;

	logic                      valid_s1;
	action_t                   action_s1;
	logic signed [COORD_W-1:0] x_op_s1;
	logic signed [COORD_W-1:0] y_op_s1;
	logic signed [TRIG_W-1:0]  sin_s1;
	logic signed [TRIG_W-1:0]  cos_s1;

	logic signed [COORD_W-1:0] vx_q [3];
	logic signed [COORD_W-1:0] vy_q [3];
	logic                      clipped_q;
	logic                      res_valid_q;

	logic                      advance;
	logic                      cmd_take;
	logic [15:0]               cos_angle;
	vertex_res_t               vres [3];

	// Handshake
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;
	assign cmd_take  = cmd_valid && cmd_ready;

	// Trig lookup on the way in
	assign cos_angle = turn_angle + QUARTER_TURN;

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			action_s1 <= action_t'(action);
			x_op_s1   <= x_operand;
			y_op_s1   <= y_operand;
			sin_s1    <= SINE_TAB[turn_angle[15 -: IDX_W]];
			cos_s1    <= SINE_TAB[cos_angle[15 -: IDX_W]];
		end
	end

	// Per-vertex datapaths
	for (genvar i = 0; i < 3; i++) begin : g_vertex
		taf_vertex u_vertex (
			.action  (action_s1),
			.x       (vx_q[i]),
			.y       (vy_q[i]),
			.x_op    (x_op_s1),
			.y_op    (y_op_s1),
			.sin_val (sin_s1),
			.cos_val (cos_s1),
			.res     (vres[i])
		);
	end

	// Vertex state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= RESET_X[i];
				vy_q[i] <= RESET_Y[i];
			end
			clipped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				for (int i = 0; i < 3; i++) begin
					vx_q[i] <= vres[i].x;
					vy_q[i] <= vres[i].y;
				end
				clipped_q   <= vres[0].clip | vres[1].clip | vres[2].clip;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign vertex_a_x = vx_q[0];
	assign vertex_a_y = vy_q[0];
	assign vertex_b_x = vx_q[1];
	assign vertex_b_y = vy_q[1];
	assign vertex_c_x = vx_q[2];
	assign vertex_c_y = vy_q[2];
	assign clipped    = clipped_q;

`ifndef SYNTHESIS
	// Vertices move only when an item completes
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(vx_q[0]) && $stable(vy_q[0]) && $stable(vx_q[1])
			&& $stable(vy_q[1]) && $stable(vx_q[2]) && $stable(vy_q[2]))
		else $error("vertex state changed without a completed item");

	// Show leaves the triangle alone and never clips
	a_show_noop: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == ACT_SHOW |=> !clipped_q && $stable(vx_q[0])
			&& $stable(vy_q[1]) && $stable(vx_q[2]))
		else $error("show command altered the vertices");

	// A waiting item is never dropped
	a_s1_keep: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage lost an item");

	// Clip flag implies a coordinate sits at a limit
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		clipped_q |->
			vx_q[0] == {1'b0, {(COORD_W-1){1'b1}}} || vx_q[0] == {1'b1, {(COORD_W-1){1'b0}}}
			|| vy_q[0] == {1'b0, {(COORD_W-1){1'b1}}} || vy_q[0] == {1'b1, {(COORD_W-1){1'b0}}}
			|| vx_q[1] == {1'b0, {(COORD_W-1){1'b1}}} || vx_q[1] == {1'b1, {(COORD_W-1){1'b0}}}
			|| vy_q[1] == {1'b0, {(COORD_W-1){1'b1}}} || vy_q[1] == {1'b1, {(COORD_W-1){1'b0}}}
			|| vx_q[2] == {1'b0, {(COORD_W-1){1'b1}}} || vx_q[2] == {1'b1, {(COORD_W-1){1'b0}}}
			|| vy_q[2] == {1'b0, {(COORD_W-1){1'b1}}} || vy_q[2] == {1'b1, {(COORD_W-1){1'b0}}})
		else $error("clipped set with no saturated coordinate");
`endif

endmodule

// ===== rtl/core/taf_vertex.sv =====
// Transform datapath for one vertex: translate, scale or rotate, then saturate.
module taf_vertex (
	input  taf_pkg::action_t                    action,
	input  logic signed [taf_pkg::COORD_W-1:0]  x,
	input  logic signed [taf_pkg::COORD_W-1:0]  y,
	input  logic signed [taf_pkg::COORD_W-1:0]  x_op,
	input  logic signed [taf_pkg::COORD_W-1:0]  y_op,
	input  logic signed [taf_pkg::TRIG_W-1:0]   sin_val,
	input  logic signed [taf_pkg::TRIG_W-1:0]   cos_val,
	output taf_pkg::vertex_res_t                res
);
	import taf_pkg::*;

	localparam int PROD_W = COORD_W + TRIG_W;
	localparam int WIDE_W = PROD_W + 2;

	logic signed [TRIG_W-1:0] fac_x;
	logic signed [TRIG_W-1:0] fac_y;
	logic signed [PROD_W-1:0] m_xa;
	logic signed [PROD_W-1:0] m_yb;
	logic signed [PROD_W-1:0] m_xs;
	logic signed [PROD_W-1:0] m_yc;
	logic signed [WIDE_W-1:0] wide_x;
	logic signed [WIDE_W-1:0] wide_y;
	logic [COORD_W:0]         sat_x;
	logic [COORD_W:0]         sat_y;

	// Clamp to 32 bits; top bit of the result is the clip flag
	function automatic logic [COORD_W:0] saturate(input logic signed [WIDE_W-1:0] v);
		logic fits;
		fits = (&v[WIDE_W-1:COORD_W-1]) || !(|v[WIDE_W-1:COORD_W-1]);
		if (fits) begin
			return {1'b0, v[COORD_W-1:0]};
		end
		return {1'b1, v[WIDE_W-1], {(COORD_W-1){~v[WIDE_W-1]}}};
	endfunction

	// Scale factors share the x*cos and y*cos multipliers
	assign fac_x = (action == ACT_SCALE) ? x_op[TRIG_W-1:0] : cos_val;
	assign fac_y = (action == ACT_SCALE) ? y_op[TRIG_W-1:0] : cos_val;

	assign m_xa = PROD_W'(x) * PROD_W'(fac_x);
	assign m_yb = PROD_W'(y) * PROD_W'(sin_val);
	assign m_xs = PROD_W'(x) * PROD_W'(sin_val);
	assign m_yc = PROD_W'(y) * PROD_W'(fac_y);

	// Exact new coordinate before clamping
	always_comb begin
		case (action)
			ACT_TRANSLATE: begin
				wide_x = WIDE_W'(x) + WIDE_W'(x_op);
				wide_y = WIDE_W'(y) + WIDE_W'(y_op);
			end
			ACT_SCALE: begin
				wide_x = (WIDE_W'(m_xa) + WIDE_W'(128)) >>> 8;
				wide_y = (WIDE_W'(m_yc) + WIDE_W'(128)) >>> 8;
			end
			ACT_ROTATE: begin
				wide_x = (WIDE_W'(m_xa) - WIDE_W'(m_yb) + WIDE_W'(8192)) >>> 14;
				wide_y = (WIDE_W'(m_xs) + WIDE_W'(m_yc) + WIDE_W'(8192)) >>> 14;
			end
			default: begin
				wide_x = WIDE_W'(x);
				wide_y = WIDE_W'(y);
			end
		endcase
	end

	assign sat_x = saturate(wide_x);
	assign sat_y = saturate(wide_y);

	assign res.x    = $signed(sat_x[COORD_W-1:0]);
	assign res.y    = $signed(sat_y[COORD_W-1:0]);
	assign res.clip = sat_x[COORD_W] | sat_y[COORD_W];

endmodule

// ===== bench/tb_triangle_affine_transform_top.sv =====
// Self-checking testbench of the triangle affine transform: scoreboard class and drivers.
module tb_triangle_affine_transform_top;
	import taf_pkg::*;

	localparam int N_RANDOM     = 800;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;

	localparam longint unsigned ONE_Q30     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30_TB = 64'd1686629713;
	localparam logic [15:0]     TURN_QUARTER = 16'h4000;
	localparam longint          COORD_MAX = (longint'(1) <<< 31) - 1;
	localparam longint          COORD_MIN = -(longint'(1) <<< 31);

	// One result: a_x, a_y, b_x, b_y, c_x, c_y from bit 0 upward, plus the flag
	typedef struct packed {
		logic [5:0][COORD_W-1:0] coord;
		logic                    clip;
	} triangle_t;

	// Scoreboard: own copy of the vertices and sine table, queue of expected results
	class triangle_board;
		logic signed [COORD_W-1:0] vx [3];
		logic signed [COORD_W-1:0] vy [3];
		int        sine_q14 [SINE_TABLE_DEPTH];
		triangle_t expected_q [$];
		bit        clip_now;
		int        errors;
		int        checked;
		int        clipped_seen;

		function new();
			for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
				sine_q14[k] = sine_of(k);
			end
			vx[0] = clamp(longint'(100) <<< FRAC_BITS);
			vx[1] = clamp(longint'(100) <<< FRAC_BITS);
			vx[2] = clamp(longint'(150) <<< FRAC_BITS);
			vy[0] = clamp(longint'(100) <<< FRAC_BITS);
			vy[1] = clamp(longint'(200) <<< FRAC_BITS);
			vy[2] = clamp(longint'(150) <<< FRAC_BITS);
			clip_now = 1'b0;
			errors = 0;
			checked = 0;
			clipped_seen = 0;
		endfunction

		// sin(2*pi*k/depth) in Q1.14: quadrant fold, then Taylor series in Q30
		function int sine_of(int k);
			longint unsigned turn, rem, theta, term, q14;
			longint          sum;
			int              quad;
			turn = ((64'(k) << 32) / 64'(SINE_TABLE_DEPTH)) & 64'hFFFF_FFFF;
			quad = int'(turn >> 30);
			rem = turn & (ONE_Q30 - 1);
			if (quad % 2 == 1) begin
				rem = ONE_Q30 - rem;
			end
			theta = (rem * HALF_PI_Q30_TB) >> 30;
			term = theta;
			sum = longint'(theta);
			for (int n = 1; n <= 7; n++) begin
				term = (((term * theta) >> 30) * theta) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			q14 = ($unsigned(sum) + 64'd32768) >> 16;
			if (q14 > 64'd16384) begin
				q14 = 64'd16384;
			end
			return (quad >= 2) ? -int'(q14) : int'(q14);
		endfunction

		function int index_of(logic [15:0] ang);
			return int'((64'(ang) * 64'(SINE_TABLE_DEPTH)) >> 16) % SINE_TABLE_DEPTH;
		endfunction

		function logic signed [COORD_W-1:0] clamp(longint v);
			if (v > COORD_MAX) begin
				clip_now = 1'b1;
				return COORD_W'(COORD_MAX);
			end
			if (v < COORD_MIN) begin
				clip_now = 1'b1;
				return COORD_W'(COORD_MIN);
			end
			return COORD_W'(v);
		endfunction

		// Largest coordinate magnitude, used to steer the random stimulus
		function longint magnitude();
			longint m;
			m = 0;
			for (int i = 0; i < 3; i++) begin
				if ((vx[i] < 0 ? -longint'(vx[i]) : longint'(vx[i])) > m)
					m = vx[i] < 0 ? -longint'(vx[i]) : longint'(vx[i]);
				if ((vy[i] < 0 ? -longint'(vy[i]) : longint'(vy[i])) > m)
					m = vy[i] < 0 ? -longint'(vy[i]) : longint'(vy[i]);
			end
			return m;
		endfunction

		// Largest distance between vertices along either axis
		function longint spread();
			longint m, d;
			m = 0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					d = longint'(vx[i]) - longint'(vx[j]);
					if (d > m) m = d;
					d = longint'(vy[i]) - longint'(vy[j]);
					if (d > m) m = d;
				end
			end
			return m;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endfunction

		// Apply one accepted command to the vertex copy and queue the result
		function void note_command(action_t act, logic signed [COORD_W-1:0] xo,
				logic signed [COORD_W-1:0] yo, logic [15:0] ang);
			longint    x, y, nx, ny, sx, sy, s, c;
			triangle_t t;
			clip_now = 1'b0;
			sx = longint'($signed(xo[15:0]));
			sy = longint'($signed(yo[15:0]));
			s = sine_q14[index_of(ang)];
			c = sine_q14[index_of(16'(ang + TURN_QUARTER))];
			for (int i = 0; i < 3; i++) begin
				x = longint'(vx[i]);
				y = longint'(vy[i]);
				case (act)
					ACT_TRANSLATE: begin
						nx = x + longint'(xo);
						ny = y + longint'(yo);
					end
					ACT_SCALE: begin
						nx = (x * sx + 128) >>> 8;
						ny = (y * sy + 128) >>> 8;
					end
					ACT_ROTATE: begin
						nx = (c * x - s * y + 8192) >>> 14;
						ny = (s * x + c * y + 8192) >>> 14;
					end
					default: begin
						nx = x;
						ny = y;
					end
				endcase
				vx[i] = clamp(nx);
				vy[i] = clamp(ny);
			end
			for (int i = 0; i < 3; i++) begin
				t.coord[2 * i]     = vx[i];
				t.coord[2 * i + 1] = vy[i];
			end
			t.clip = clip_now;
			expected_q.push_back(t);
		endfunction

		// Compare one accepted result against the oldest expectation
		function void check_result(triangle_t got);
			string     names [6];
			triangle_t want;
			names = '{"vertex_a_x", "vertex_a_y", "vertex_b_x", "vertex_b_y",
				"vertex_c_x", "vertex_c_y"};
			if (expected_q.size() == 0) begin
				report("result arrived with no command outstanding");
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (want.clip) clipped_seen++;
			for (int k = 0; k < 6; k++) begin
				if (got.coord[k] !== want.coord[k])
					report($sformatf("result %0d %s got %h want %h", checked, names[k],
						got.coord[k], want.coord[k]));
			end
			if (got.clip !== want.clip)
				report($sformatf("result %0d clipped got %b want %b", checked, got.clip,
					want.clip));
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cmd_valid;
	logic                      cmd_ready;
	logic [1:0]                action;
	logic signed [COORD_W-1:0] x_operand;
	logic signed [COORD_W-1:0] y_operand;
	logic [15:0]               turn_angle;
	logic                      res_valid;
	logic                      res_ready;
	logic signed [COORD_W-1:0] vertex_a_x, vertex_a_y;
	logic signed [COORD_W-1:0] vertex_b_x, vertex_b_y;
	logic signed [COORD_W-1:0] vertex_c_x, vertex_c_y;
	logic                      clipped;

	triangle_board board;
	int            send_pct;
	int            recv_pct;
	int            act_count [4];

	triangle_affine_transform_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.action     (action),
		.x_operand  (x_operand),
		.y_operand  (y_operand),
		.turn_angle (turn_angle),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.vertex_a_x (vertex_a_x),
		.vertex_a_y (vertex_a_y),
		.vertex_b_x (vertex_b_x),
		.vertex_b_y (vertex_b_y),
		.vertex_c_x (vertex_c_x),
		.vertex_c_y (vertex_c_y),
		.clipped    (clipped)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle length: none at pct 0, mostly short, now and then long
	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Present one item and hold it until the block takes it
	task automatic send_cmd(action_t act, logic signed [COORD_W-1:0] xo,
			logic signed [COORD_W-1:0] yo, logic [15:0] ang);
		int gap;
		gap = pick_gap(send_pct);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid  <= 1'b1;
		action     <= act;
		x_operand  <= xo;
		y_operand  <= yo;
		turn_angle <= ang;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		board.note_command(act, xo, yo, ang);
		act_count[act]++;
	endtask

	// Random command, steered so the triangle stays neither huge nor collapsed
	task automatic send_random();
		action_t                   act;
		logic signed [COORD_W-1:0] xo, yo;
		logic [15:0]               ang, fx, fy;
		int                        pick;
		xo = $urandom;
		yo = $urandom;
		ang = 16'($urandom);
		fx = 16'(224 + $urandom_range(0, 64));
		fy = 16'(224 + $urandom_range(0, 64));
		if ($urandom_range(0, 3) == 0) fx = -fx;
		if ($urandom_range(0, 3) == 0) fy = -fy;
		pick = $urandom_range(0, 99);
		if (board.magnitude() > (longint'(1) <<< 29) && pick < 70) begin
			if (board.spread() > (longint'(1) <<< 28)) begin
				act = ACT_SCALE;
				xo = {16'($urandom), 16'h0040};
				yo = {16'($urandom), 16'h0040};
			end else begin
				act = ACT_TRANSLATE;
				xo = -(board.vx[0] >>> 1);
				yo = -(board.vy[0] >>> 1);
			end
		end else if (board.spread() != 0 && board.spread() < 4096) begin
			act = ACT_SCALE;
			xo = {16'($urandom), 16'h4000};
			yo = {16'($urandom), 16'h4000};
		end else if (pick < 30) begin
			act = ACT_ROTATE;
		end else if (pick < 55) begin
			act = ACT_TRANSLATE;
			xo = int'($urandom_range(0, 2097152)) - 1048576;
			yo = int'($urandom_range(0, 2097152)) - 1048576;
		end else if (pick < 80) begin
			act = ACT_SCALE;
			xo = {16'($urandom), fx};
			yo = {16'($urandom), fy};
		end else if (pick < 88) begin
			act = ACT_SHOW;
		end else if (pick < 94) begin
			// bounded offset on one axis, full-range random offset on the other
			act = ACT_TRANSLATE;
			if ($urandom_range(0, 1)) xo = int'($urandom_range(0, 2097152)) - 1048576;
			else yo = int'($urandom_range(0, 2097152)) - 1048576;
		end else begin
			// bounded factor on one axis, full-range random factor on the other
			act = ACT_SCALE;
			if ($urandom_range(0, 1)) xo = {16'($urandom), fx};
			else yo = {16'($urandom), fy};
		end
		send_cmd(act, xo, yo, ang);
	endtask

	// Result side: check each accepted result, then pick ready for the next edge
	initial begin
		int stall_left;
		triangle_t got;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				got.coord = {vertex_c_y, vertex_c_x, vertex_b_y, vertex_b_x,
					vertex_a_y, vertex_a_x};
				got.clip = clipped;
				board.check_result(got);
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				stall_left = pick_gap(recv_pct);
			end
		end
	end

	// Watchdog: too many cycles in a row with no item moving on either side
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) quiet = 0;
			else quiet++;
		end
		$display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
		$display("** triangle_affine_transform_top: FAILED **");
		$finish;
	end

	// Main sequence: reset, directed commands, random phases, drain
	initial begin
		board = new();
		act_count = '{0, 0, 0, 0};
		arst_n     = 1'b0;
		cmd_valid  = 1'b0;
		action     = ACT_SHOW;
		x_operand  = '0;
		y_operand  = '0;
		turn_angle = '0;
		res_ready  = 1'b0;
		send_pct   = 20;
		recv_pct   = 20;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every command, operand extremes, saturation in each arithmetic path
		send_cmd(ACT_SHOW, $urandom, $urandom, 16'($urandom));
		send_cmd(ACT_TRANSLATE, 32'sh0001_8000, -32'sh0002_4000, 16'($urandom));
		send_cmd(ACT_SCALE, 32'hABCD_0100, 32'h1234_0100, 16'($urandom));
		send_cmd(ACT_SCALE, 32'h0000_0180, 32'hFFFF_FF80, 16'($urandom));
		send_cmd(ACT_ROTATE, $urandom, $urandom, 16'h4000);
		send_cmd(ACT_ROTATE, $urandom, $urandom, 16'h8000);
		send_cmd(ACT_ROTATE, $urandom, $urandom, 16'hC000);
		send_cmd(ACT_ROTATE, $urandom, $urandom, 16'h0000);
		send_cmd(ACT_ROTATE, $urandom, $urandom, 16'hFFFF);
		send_cmd(ACT_ROTATE, $urandom, $urandom, 16'h00FF);
		send_cmd(ACT_TRANSLATE, 32'sh7FFF_FFFF, 32'sh0000_0000, 16'($urandom));
		send_cmd(ACT_TRANSLATE, 32'sh7FFF_FFFF, 32'sh0000_0000, 16'($urandom));
		send_cmd(ACT_TRANSLATE, 32'sh8000_0000, 32'sh0000_0000, 16'($urandom));
		send_cmd(ACT_TRANSLATE, 32'sh8000_0000, 32'sh0000_0000, 16'($urandom));
		send_cmd(ACT_ROTATE, $urandom, $urandom, 16'h2000);
		send_cmd(ACT_SCALE, 32'h0000_7FFF, 32'hFFFF_0100, 16'($urandom));
		send_cmd(ACT_ROTATE, $urandom, $urandom, 16'h4000);
		send_cmd(ACT_SCALE, 32'h0000_0100, 32'h0000_8000, 16'($urandom));
		send_cmd(ACT_ROTATE, $urandom, $urandom, 16'h2000);
		send_cmd(ACT_SCALE, 32'h0000_0001, 32'h0000_0001, 16'($urandom));
		send_cmd(ACT_SHOW, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF);

		// random phases with different idling on each side
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_pct = 0;  recv_pct = 0;  end
				1: begin send_pct = 30; recv_pct = 30; end
				2: begin send_pct = 10; recv_pct = 60; end
				default: begin send_pct = 60; recv_pct = 10; end
			endcase
			for (int n = 0; n < N_RANDOM / 4; n++) begin
				send_random();
			end
			// hold off once until the block has emptied
			if (phase == 1) begin
				cmd_valid <= 1'b0;
				@(posedge clk);
				while (board.pending() != 0) @(posedge clk);
			end
		end

		// collapse to the origin with a zero factor, then a few commands on a point
		send_cmd(ACT_SCALE, {16'($urandom), 16'h0000}, {16'($urandom), 16'h0000},
			16'($urandom));
		send_cmd(ACT_TRANSLATE, 32'sh0003_0000, -32'sh0005_0000, 16'($urandom));
		send_cmd(ACT_ROTATE, $urandom, $urandom, 16'($urandom));
		send_cmd(ACT_SHOW, $urandom, $urandom, 16'($urandom));

		cmd_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.pending() != 0)
			board.report($sformatf("%0d results never arrived", board.pending()));
		$display("Commands: %0d show, %0d translate, %0d scale, %0d rotate.",
			act_count[ACT_SHOW], act_count[ACT_TRANSLATE], act_count[ACT_SCALE],
			act_count[ACT_ROTATE]);
		$display("Results checked: %0d, %0d of them saturated; mismatches: %0d.",
			board.checked, board.clipped_seen, board.errors);
		if (board.errors == 0) begin
			$display("** triangle_affine_transform_top: PASSED **");
		end else begin
			$display("** triangle_affine_transform_top: FAILED **");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/taf_pkg.sv
rtl/core/taf_vertex.sv
rtl/core/triangle_affine_transform_top.sv
bench/tb_triangle_affine_transform_top.sv
